// ----- sv/dq_pkg.sv -----
package dq_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OCC_W     = 7;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef struct packed {
    logic exec;
    logic load;
  } dq_cmd_t;

  typedef struct packed {
    logic need_read;
  } dq_status_t;

endpackage

// ----- sv/double_ended_queue_core.sv -----
// a push result is valid in the cycle after the request edge; a pop that leaves
// entries behind passes ST_READ (one registered ring read refetches the new front
// or back) before ST_RESP; any other pop goes straight to ST_RESP
// a new request is taken only once the result has been accepted in ST_RESP
// reset: head, tail and count cleared; ring storage keeps its contents, no init pass
module double_ended_queue_core import dq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // push_value
  input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // popped_value, front_value, back_value, is_empty, underflow, overflow,
  // occupancy, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  dq_cmd_t           cmd;
  dq_status_t        status;
  logic [DATA_W-1:0] popped_value, front_value, back_value;
  logic              is_empty, underflow, overflow;
  logic [OCC_W-1:0]  occupancy;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (s_axis_tuser),
    .push_value_i   (s_axis_tdata),
    .popped_value_o (popped_value),
    .front_value_o  (front_value),
    .back_value_o   (back_value),
    .is_empty_o     (is_empty),
    .underflow_o    (underflow),
    .overflow_o     (overflow),
    .occupancy_o    (occupancy)
  );

  assign m_axis_tdata = {6'b0, occupancy, overflow, underflow, is_empty,
                         back_value, front_value, popped_value};

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while result pending");
`endif

endmodule

// ----- sv/dq_ram.sv -----
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dq_ctrl.sv -----
module dq_ctrl import dq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dq_status_t status_i,
  output dq_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = status_i.need_read ? ST_READ : ST_RESP;
        end
      end
      ST_READ: begin
        cmd_o.load = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o)
    else $error("load not followed by result");
  a_exec_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec && status_i.need_read) |=> cmd_o.load)
    else $error("pop read not loaded");
`endif

endmodule

// ----- sv/dq_datapath.sv -----
module dq_datapath import dq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dq_cmd_t           cmd_i,
  output dq_status_t        status_o,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [DATA_W-1:0] push_value_i,
  output logic [DATA_W-1:0] popped_value_o,
  output logic [DATA_W-1:0] front_value_o,
  output logic [DATA_W-1:0] back_value_o,
  output logic              is_empty_o,
  output logic              underflow_o,
  output logic              overflow_o,
  output logic [OCC_W-1:0]  occupancy_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  head_q, tail_q;
  logic [CNT_W-1:0]  count_q;
  logic [DATA_W-1:0] front_q, back_q, popped_q;
  logic              uflow_q, oflow_q, load_front_q;

  logic [IDX_W-1:0]  head_prev, head_next, tail_prev, tail_next, tail_prev2;
  logic              is_push, full, empty;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CNT_W+OCC_W-1:0] cnt_ext;
  req_e              req;

  assign req   = req_e'(req_type_i);
  assign is_push = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign head_prev  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
  assign head_next  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_prev  = (tail_q == '0) ? IDX_W'(DEPTH - 1) : tail_q - 1'b1;
  assign tail_next  = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_prev2 = (tail_prev == '0) ? IDX_W'(DEPTH - 1) : tail_prev - 1'b1;

  // a pop leaving entries behind refetches the new end from the ring
  assign status_o.need_read = !is_push && (count_q > CNT_W'(1));

  assign ram_we    = cmd_i.exec && is_push && !full;
  assign ram_waddr = (req == REQ_PUSH_FRONT) ? head_prev : tail_q;
  assign ram_re    = cmd_i.exec && status_o.need_read;
  assign ram_raddr = (req == REQ_POP_FRONT) ? head_next : tail_prev2;

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      front_q      <= '0;
      back_q       <= '0;
      popped_q     <= '0;
      uflow_q      <= 1'b0;
      oflow_q      <= 1'b0;
      load_front_q <= 1'b0;
    end else if (cmd_i.exec) begin
      uflow_q      <= !is_push && empty;
      oflow_q      <= is_push && full;
      popped_q     <= '0;
      load_front_q <= (req == REQ_POP_FRONT);
      case (req)
        REQ_PUSH_FRONT: begin
          if (!full) begin
            head_q  <= head_prev;
            count_q <= count_q + 1'b1;
            front_q <= push_value_i;
            if (empty) begin
              back_q <= push_value_i;
            end
          end
        end
        REQ_PUSH_BACK: begin
          if (!full) begin
            tail_q  <= tail_next;
            count_q <= count_q + 1'b1;
            back_q  <= push_value_i;
            if (empty) begin
              front_q <= push_value_i;
            end
          end
        end
        REQ_POP_FRONT: begin
          if (!empty) begin
            popped_q <= front_q;
            head_q   <= head_next;
            count_q  <= count_q - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (!empty) begin
            popped_q <= back_q;
            tail_q   <= tail_prev;
            count_q  <= count_q - 1'b1;
          end
        end
        default: begin
          popped_q <= '0;
        end
      endcase
    end else if (cmd_i.load) begin
      if (load_front_q) begin
        front_q <= ram_rdata;
      end else begin
        back_q <= ram_rdata;
      end
    end
  end

  assign cnt_ext        = {{OCC_W{1'b0}}, count_q};
  assign popped_value_o = popped_q;
  assign front_value_o  = empty ? '1 : front_q;
  assign back_value_o   = empty ? '1 : back_q;
  assign is_empty_o     = empty;
  assign underflow_o    = uflow_q;
  assign overflow_o     = oflow_q;
  assign occupancy_o    = cnt_ext[OCC_W-1:0];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count beyond depth");
  a_oflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oflow_q |-> full)
    else $error("overflow while not full");
  a_uflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uflow_q |-> empty)
    else $error("underflow while not empty");
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("write and read in one request");
`endif

endmodule
